FILE: rtl/pixel_format_converter_defines.svh
// ----------------------------------------------------------------------------
// pixel_format_converter_defines
// Assertion macros shared by the checker of the pixel format converter.
// ----------------------------------------------------------------------------
`ifndef PIXEL_FORMAT_CONVERTER_DEFINES_SVH
`define PIXEL_FORMAT_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PFC_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pixel format converter: assertion failed");

// Next-cycle implication, disabled during reset.
`define PFC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pixel format converter: assertion failed");

`endif

FILE: rtl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Types, codes and helper functions of the pixel format converter.
// ----------------------------------------------------------------------------
package pfc_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int SIZE_W = 13;
   localparam int FMT_W  = 3;
   localparam int SHIFT_W = 4;
   localparam int PIX_W  = 32;
   localparam int ADDR_W = 26;
   localparam int COUNT_W = 3;
   localparam int STATUS_W = 2;
   localparam int INDEX_W = 3;

   // Format codes
   localparam logic [FMT_W-1:0] FMT_RGBA8888 = 3'd0;
   localparam logic [FMT_W-1:0] FMT_RGB565   = 3'd1;
   localparam logic [FMT_W-1:0] FMT_I8       = 3'd2;
   localparam logic [FMT_W-1:0] FMT_D16      = 3'd3;
   localparam logic [FMT_W-1:0] FMT_RGB888   = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PAIR = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SIZE = 2'd2;

   // Register indexes
   localparam logic [INDEX_W-1:0] REG_SOURCE_FORMAT = 3'd0;
   localparam logic [INDEX_W-1:0] REG_TARGET_FORMAT = 3'd1;
   localparam logic [INDEX_W-1:0] REG_SOURCE_WIDTH  = 3'd2;
   localparam logic [INDEX_W-1:0] REG_SOURCE_HEIGHT = 3'd3;
   localparam logic [INDEX_W-1:0] REG_TARGET_WIDTH  = 3'd4;
   localparam logic [INDEX_W-1:0] REG_TARGET_HEIGHT = 3'd5;
   localparam logic [INDEX_W-1:0] REG_DEPTH_SHIFT   = 3'd6;

   typedef struct packed {
      logic [FMT_W-1:0]   source_format;
      logic [FMT_W-1:0]   target_format;
      logic [SIZE_W-1:0]  source_width;
      logic [SIZE_W-1:0]  source_height;
      logic [SIZE_W-1:0]  target_width;
      logic [SIZE_W-1:0]  target_height;
      logic [SHIFT_W-1:0] depth_shift;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0] offset;
      logic              last;
   } scan_type;

   // Pixel size in bytes; codes without a format give zero.
   function automatic logic [COUNT_W-1:0] pixel_bytes(input logic [FMT_W-1:0] fmt);
      logic [COUNT_W-1:0] n;
      n = '0;
      case (fmt)
         FMT_RGBA8888: n = 3'd4;
         FMT_RGB565:   n = 3'd2;
         FMT_I8:       n = 3'd1;
         FMT_D16:      n = 3'd2;
         FMT_RGB888:   n = 3'd3;
         default:      n = '0;
      endcase
      return n;
   endfunction

endpackage

FILE: rtl/pfc_csr.sv
// ----------------------------------------------------------------------------
// pfc_csr
// Configuration registers and the format pair and size checks.
// ----------------------------------------------------------------------------
module pfc_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [pfc_pkg::INDEX_W-1:0]  csr_index,
   input  logic [pfc_pkg::SIZE_W-1:0]   csr_write_data,
   output pfc_pkg::cfg_type             cfg,
   output logic [pfc_pkg::STATUS_W-1:0] status,
   output logic                         restart
);
   import pfc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    hit;
   logic    pair_ok;
   logic    size_ok;
   logic [FMT_W-1:0] sf;
   logic [FMT_W-1:0] tf;

   always_comb begin
      cfg_in = cfg_ff;
      hit    = 1'b0;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_SOURCE_FORMAT: begin
               cfg_in.source_format = csr_write_data[FMT_W-1:0];
               hit = 1'b1;
            end
            REG_TARGET_FORMAT: begin
               cfg_in.target_format = csr_write_data[FMT_W-1:0];
               hit = 1'b1;
            end
            REG_SOURCE_WIDTH: begin
               cfg_in.source_width = csr_write_data;
               hit = 1'b1;
            end
            REG_SOURCE_HEIGHT: begin
               cfg_in.source_height = csr_write_data;
               hit = 1'b1;
            end
            REG_TARGET_WIDTH: begin
               cfg_in.target_width = csr_write_data;
               hit = 1'b1;
            end
            REG_TARGET_HEIGHT: begin
               cfg_in.target_height = csr_write_data;
               hit = 1'b1;
            end
            REG_DEPTH_SHIFT: begin
               cfg_in.depth_shift = csr_write_data[SHIFT_W-1:0];
               hit = 1'b1;
            end
            default: hit = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{source_format: FMT_RGBA8888, target_format: FMT_RGBA8888,
                     source_width: '0, source_height: '0, target_width: '0,
                     target_height: '0, depth_shift: 4'd8};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign sf = cfg_ff.source_format;
   assign tf = cfg_ff.target_format;

   always_comb begin
      if (sf > FMT_RGB888 || tf > FMT_RGB888) begin
         pair_ok = 1'b0;
      end else if (sf == tf) begin
         pair_ok = 1'b1;
      end else if (tf == FMT_RGBA8888) begin
         pair_ok = (sf == FMT_RGB888) || (sf == FMT_D16);
      end else if (tf == FMT_RGB888) begin
         pair_ok = (sf == FMT_RGBA8888) || (sf == FMT_D16);
      end else if (tf == FMT_RGB565) begin
         pair_ok = (sf == FMT_RGB888) || (sf == FMT_RGBA8888) || (sf == FMT_D16);
      end else begin
         pair_ok = 1'b0;
      end
   end

   assign size_ok = (cfg_ff.source_width != '0) && (cfg_ff.source_height != '0) &&
                    (cfg_ff.target_width != '0) && (cfg_ff.target_height != '0) &&
                    (cfg_ff.source_width <= cfg_ff.target_width) &&
                    (cfg_ff.source_height <= cfg_ff.target_height) &&
                    (32'(cfg_ff.source_width) <= 32'(MAX_WIDTH)) &&
                    (32'(cfg_ff.source_height) <= 32'(MAX_HEIGHT));

   assign status  = !pair_ok ? STATUS_PAIR : (!size_ok ? STATUS_SIZE : STATUS_OK);
   assign cfg     = cfg_ff;
   assign restart = hit;

endmodule

FILE: rtl/pfc_scan.sv
// ----------------------------------------------------------------------------
// pfc_scan
// Raster position counters; keep row*stride as a running base.
// ----------------------------------------------------------------------------
module pfc_scan (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       restart,
   input  logic                       advance,
   input  logic [pfc_pkg::SIZE_W-1:0] source_width,
   input  logic [pfc_pkg::SIZE_W-1:0] source_height,
   input  logic [pfc_pkg::SIZE_W-1:0] target_width,
   output pfc_pkg::scan_type          scan
);
   import pfc_pkg::*;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic              col_last;
   logic              row_last;

   assign col_last = (32'(col_ff) + 32'd1) >= 32'(source_width);
   assign row_last = (32'(row_ff) + 32'd1) >= 32'(source_height);

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      base_in = base_ff;
      if (restart) begin
         col_in  = '0;
         row_in  = '0;
         base_in = '0;
      end else if (advance) begin
         if (col_last) begin
            col_in = '0;
            if (row_last) begin
               row_in  = '0;
               base_in = '0;
            end else begin
               row_in  = row_ff + 1'b1;
               base_in = base_ff + ADDR_W'(target_width);
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         base_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         base_ff <= base_in;
      end
   end

   assign scan.offset = base_ff + ADDR_W'(col_ff);
   assign scan.last   = col_last && row_last;

endmodule

FILE: rtl/pfc_convert.sv
// ----------------------------------------------------------------------------
// pfc_convert
// Color conversion of one pixel for the configured format pair.
// ----------------------------------------------------------------------------
module pfc_convert (
   input  logic [pfc_pkg::FMT_W-1:0]   source_format,
   input  logic [pfc_pkg::FMT_W-1:0]   target_format,
   input  logic [pfc_pkg::SHIFT_W-1:0] depth_shift,
   input  logic [pfc_pkg::PIX_W-1:0]   pixel_in,
   output logic [pfc_pkg::PIX_W-1:0]   pixel_out
);
   import pfc_pkg::*;

   logic [7:0]  r, g, b, c;
   logic [15:0] depth;
   logic [PIX_W-1:0] rgb_565;
   logic [PIX_W-1:0] gray_565;
   logic [PIX_W-1:0] copy;

   assign r     = pixel_in[7:0];
   assign g     = pixel_in[15:8];
   assign b     = pixel_in[23:16];
   assign depth = pixel_in[15:0] >> depth_shift;
   assign c     = depth[7:0];

   assign rgb_565  = {16'd0, r[7:3], g[7:2], b[7:3]};
   assign gray_565 = {16'd0, c[7:3], c[7:2], c[7:3]};

   // Same format: keep the bytes of the pixel size
   always_comb begin
      case (pixel_bytes(source_format))
         3'd1:    copy = {24'd0, pixel_in[7:0]};
         3'd2:    copy = {16'd0, pixel_in[15:0]};
         3'd3:    copy = {8'd0, pixel_in[23:0]};
         default: copy = pixel_in;
      endcase
   end

   always_comb begin
      if (source_format == target_format) begin
         pixel_out = copy;
      end else if (source_format == FMT_D16) begin
         case (target_format)
            FMT_RGB888:   pixel_out = {8'd0, c, c, c};
            FMT_RGBA8888: pixel_out = {8'hFF, c, c, c};
            FMT_RGB565:   pixel_out = gray_565;
            default:      pixel_out = '0;
         endcase
      end else begin
         case (target_format)
            FMT_RGBA8888: pixel_out = {8'hFF, b, g, r};
            FMT_RGB888:   pixel_out = {8'd0, b, g, r};
            FMT_RGB565:   pixel_out = rgb_565;
            default:      pixel_out = '0;
         endcase
      end
   end

endmodule

FILE: rtl/pixel_format_converter.sv
// Input accept to result valid: through the input register, then the result register.
// Throughput: one item per cycle unless output stalls; two registers then hold two items.
// The rate is set by the running row base in the scan counters, which needs no multiplier.
// Reset (synchronous, active high) empties both registers, zeroes the counters and
// loads register defaults: formats RGBA8888, all sizes 0, depth shift 8.
// ----------------------------------------------------------------------------
// pixel_format_converter
// Converts raster-order source pixels to the destination format and gives the
// byte address of each in the destination surface.
// ----------------------------------------------------------------------------
module pixel_format_converter (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [pfc_pkg::INDEX_W-1:0]  csr_index,
   input  logic [pfc_pkg::SIZE_W-1:0]   csr_write_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [pfc_pkg::PIX_W-1:0]    req_pixel_in,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [pfc_pkg::PIX_W-1:0]    rsp_pixel_out,
   output logic [pfc_pkg::COUNT_W-1:0]  rsp_byte_count,
   output logic [pfc_pkg::ADDR_W-1:0]   rsp_byte_address,
   output logic [pfc_pkg::STATUS_W-1:0] rsp_status,
   output logic                         rsp_image_done
);
   import pfc_pkg::*;

   cfg_type              cfg;
   logic [STATUS_W-1:0]  cfg_status;
   logic                 restart;
   scan_type             scan;
   logic                 req_take;
   logic                 out_free;
   logic                 move;

   // Input register: pixel, its surface offset, end-of-image flag and status
   logic                 s1_valid_ff;
   logic [PIX_W-1:0]     s1_pixel_ff;
   logic [ADDR_W-1:0]    s1_offset_ff;
   logic                 s1_last_ff;
   logic [STATUS_W-1:0]  s1_status_ff;

   // Result register
   logic                 rsp_valid_ff;
   logic [PIX_W-1:0]     pixel_ff, pixel_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]    address_ff, address_in;
   logic [STATUS_W-1:0]  status_ff;
   logic                 done_ff, done_in;

   logic [PIX_W-1:0]     converted;
   logic [COUNT_W-1:0]   bytes;
   logic [ADDR_W-1:0]    scaled;

   pfc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg),
      .status           (cfg_status),
      .restart          (restart)
   );

   // Advance the raster position only for items that will be written
   pfc_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .restart       (restart),
      .advance       (req_take && (cfg_status == STATUS_OK)),
      .source_width  (cfg.source_width),
      .source_height (cfg.source_height),
      .target_width  (cfg.target_width),
      .scan          (scan)
   );

   pfc_convert u_convert (
      .source_format (cfg.source_format),
      .target_format (cfg.target_format),
      .depth_shift   (cfg.depth_shift),
      .pixel_in      (s1_pixel_ff),
      .pixel_out     (converted)
   );

   // Handshake: the result register frees when empty or taken; the input
   // register frees when empty or moving forward.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign move      = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pixel_ff  <= req_pixel_in;
         s1_offset_ff <= scan.offset;
         s1_last_ff   <= scan.last;
         s1_status_ff <= cfg_status;
      end
   end

   // Scale the offset by the destination pixel size
   assign bytes = pixel_bytes(cfg.target_format);

   always_comb begin
      case (bytes)
         3'd2:    scaled = {s1_offset_ff[ADDR_W-2:0], 1'b0};
         3'd3:    scaled = s1_offset_ff + {s1_offset_ff[ADDR_W-2:0], 1'b0};
         3'd4:    scaled = {s1_offset_ff[ADDR_W-3:0], 2'b00};
         default: scaled = s1_offset_ff;
      endcase
   end

   // Drop all fields but status on an error
   always_comb begin
      if (s1_status_ff == STATUS_OK) begin
         pixel_in   = converted;
         count_in   = bytes;
         address_in = scaled;
         done_in    = s1_last_ff;
      end else begin
         pixel_in   = '0;
         count_in   = '0;
         address_in = '0;
         done_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         pixel_ff   <= pixel_in;
         count_ff   <= count_in;
         address_ff <= address_in;
         status_ff  <= s1_status_ff;
         done_ff    <= done_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_out    = pixel_ff;
   assign rsp_byte_count   = count_ff;
   assign rsp_byte_address = address_ff;
   assign rsp_status       = status_ff;
   assign rsp_image_done   = done_ff;

endmodule

FILE: rtl/pfc_checker.sv
// ----------------------------------------------------------------------------
// pfc_checker
// Port-level checks of the pixel format converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "pixel_format_converter_defines.svh"

module pfc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         csr_write_enable,
   input logic [pfc_pkg::INDEX_W-1:0]  csr_index,
   input logic [pfc_pkg::SIZE_W-1:0]   csr_write_data,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [pfc_pkg::PIX_W-1:0]    req_pixel_in,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [pfc_pkg::PIX_W-1:0]    rsp_pixel_out,
   input logic [pfc_pkg::COUNT_W-1:0]  rsp_byte_count,
   input logic [pfc_pkg::ADDR_W-1:0]   rsp_byte_address,
   input logic [pfc_pkg::STATUS_W-1:0] rsp_status,
   input logic                         rsp_image_done
);
   import pfc_pkg::*;

   logic unused;
   assign unused = ^{csr_write_enable, csr_index, csr_write_data, req_pixel_in};

   // A held result keeps its payload
   `PFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_byte_address))

   // An error result carries nothing to store
   `PFC_ASSERT_IMP(a_error_empty, clock, reset, rsp_valid && (rsp_status != STATUS_OK),
      (rsp_byte_count == '0) && (rsp_byte_address == '0) && (rsp_pixel_out == '0) &&
      !rsp_image_done)

   // A written result always stores at least one byte
   `PFC_ASSERT_IMP(a_written_bytes, clock, reset, rsp_valid && (rsp_status == STATUS_OK),
      rsp_byte_count != '0)

   // With both registers full and the output stalled, no item enters
   `PFC_ASSERT_IMP(a_full_stall, clock, reset,
      rsp_valid && !rsp_ready && $past(rsp_valid && !rsp_ready && !req_ready) &&
      $past(!reset), !req_ready || !$past(req_valid))

endmodule

bind pixel_format_converter pfc_checker u_pfc_checker (.*);

FILE: tb/sv/pixel_format_converter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_converter_test
// Self-checking bench for the pixel format converter. Programs the registers,
// streams pixel items with random gaps and back-pressure, and compares every
// result with a behavioral copy of the conversion and the scan address logic.
// ----------------------------------------------------------------------------
module pixel_format_converter_test;
   import pfc_pkg::*;

   // Codes with no format behind them, for the unsupported-pair case
   localparam logic [FMT_W-1:0]   FMT_RESERVED  = 3'd5;
   localparam logic [FMT_W-1:0]   FMT_UNDEFINED = 3'd7;
   // Index past the register list: written, but must change nothing
   localparam logic [INDEX_W-1:0] REG_UNUSED    = 3'd7;
   localparam logic [7:0]         OPAQUE_ALPHA  = 8'hFF;
   localparam int                 WATCHDOG_LIMIT = 2000;
   localparam int                 RANDOM_ITEMS   = 1850;
   localparam int                 EXTREME_ITEMS  = 48;

   // One destination write as the block reports it
   typedef struct packed {
      logic [PIX_W-1:0]    pixel;
      logic [COUNT_W-1:0]  count;
      logic [ADDR_W-1:0]   address;
      logic [STATUS_W-1:0] status;
      logic                done;
   } pixel_write_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [INDEX_W-1:0]  csr_index        = '0;
   logic [SIZE_W-1:0]   csr_write_data   = '0;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [PIX_W-1:0]    req_pixel_in     = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [PIX_W-1:0]    rsp_pixel_out;
   logic [COUNT_W-1:0]  rsp_byte_count;
   logic [ADDR_W-1:0]   rsp_byte_address;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_image_done;

   // Register mirror and scan position of the behavioral copy
   cfg_type             regs;
   logic [COL_W-1:0]    scan_col;
   logic [ROW_W-1:0]    scan_row;

   pixel_write_type     destination_writes[$];

   bit                  stalls_enabled = 1'b1;
   int                  ready_hold     = 0;
   int                  ready_draw;
   int                  quiet_cycles   = 0;
   int                  mismatches     = 0;
   int                  items_sent     = 0;
   int                  images_seen    = 0;
   int                  rejects_seen   = 0;
   int                  settings_used  = 0;

   pixel_format_converter i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_in     (req_pixel_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_byte_address (rsp_byte_address),
      .rsp_status       (rsp_status),
      .rsp_image_done   (rsp_image_done)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Behavioral copy of the block
   // ------------------------------------------------------------------------
   function automatic int unsigned bytes_per_pixel(input logic [FMT_W-1:0] fmt);
      case (fmt)
         FMT_RGBA8888: return 4;
         FMT_RGB565:   return 2;
         FMT_I8:       return 1;
         FMT_D16:      return 2;
         FMT_RGB888:   return 3;
         default:      return 0;
      endcase
   endfunction

   function automatic logic [PIX_W-1:0] pack_565(input logic [7:0] r, g, b);
      return {16'h0000, r[7:3], g[7:2], b[7:3]};
   endfunction

   // Convert one pixel; return 0 when the pair has no conversion.
   function automatic bit convert_pixel(input logic [FMT_W-1:0] sf, tf,
                                        input logic [SHIFT_W-1:0] shift,
                                        input logic [PIX_W-1:0] pin,
                                        output logic [PIX_W-1:0] pout);
      logic [7:0] r, g, b, gray;
      r    = pin[7:0];
      g    = pin[15:8];
      b    = pin[23:16];
      // depth keeps only the low 8 bits after the shift
      gray = 8'(pin[15:0] >> shift);
      pout = '0;
      if (sf > FMT_RGB888 || tf > FMT_RGB888) begin
         return 1'b0;
      end else if (sf == tf) begin
         case (bytes_per_pixel(sf))
            4:       pout = pin;
            3:       pout = {8'h00, pin[23:0]};
            2:       pout = {16'h0000, pin[15:0]};
            default: pout = {24'h000000, pin[7:0]};
         endcase
      end else if (sf == FMT_RGB888 && tf == FMT_RGBA8888) begin
         pout = {OPAQUE_ALPHA, b, g, r};
      end else if (sf == FMT_RGBA8888 && tf == FMT_RGB888) begin
         pout = {8'h00, b, g, r};
      end else if ((sf == FMT_RGB888 || sf == FMT_RGBA8888) && tf == FMT_RGB565) begin
         pout = pack_565(r, g, b);
      end else if (sf == FMT_D16 && tf == FMT_RGB888) begin
         pout = {8'h00, gray, gray, gray};
      end else if (sf == FMT_D16 && tf == FMT_RGBA8888) begin
         pout = {OPAQUE_ALPHA, gray, gray, gray};
      end else if (sf == FMT_D16 && tf == FMT_RGB565) begin
         pout = pack_565(gray, gray, gray);
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // Convert, place at the scan position and advance the scan; an error gives only a status.
   function automatic pixel_write_type place_pixel(input logic [PIX_W-1:0] pin);
      pixel_write_type w;
      logic [PIX_W-1:0] pout;
      int unsigned n;
      int unsigned offset;
      w = '0;
      if (!convert_pixel(regs.source_format, regs.target_format, regs.depth_shift,
                         pin, pout)) begin
         w.status = STATUS_PAIR;
         return w;
      end
      if (regs.source_width == 0 || regs.source_height == 0 ||
          regs.target_width == 0 || regs.target_height == 0 ||
          regs.source_width > regs.target_width ||
          regs.source_height > regs.target_height ||
          regs.source_width > MAX_WIDTH || regs.source_height > MAX_HEIGHT) begin
         w.status = STATUS_SIZE;
         return w;
      end
      n      = bytes_per_pixel(regs.target_format);
      offset = (scan_row * regs.target_width + scan_col) * n;
      if (scan_col + 1 >= regs.source_width) begin
         scan_col = '0;
         if (scan_row + 1 >= regs.source_height) begin
            scan_row = '0;
            w.done   = 1'b1;
         end else begin
            scan_row = scan_row + 1'b1;
         end
      end else begin
         scan_col = scan_col + 1'b1;
      end
      w.pixel   = pout;
      w.count   = COUNT_W'(n);
      w.address = offset[ADDR_W-1:0];
      w.status  = STATUS_OK;
      return w;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [PIX_W-1:0] random_pixel();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Present one pixel item after a random gap and hold it until taken.
   // Valid stays high on return so a back-to-back item follows without a gap.
   task automatic send_pixel(input logic [PIX_W-1:0] pin);
      int gap;
      gap = stalls_enabled ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= pin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      destination_writes.push_back(place_pixel(pin));
      items_sent++;
   endtask

   // Drop valid, wait for every outstanding result, then let the pipe empty.
   task automatic drain_and_idle();
      req_valid <= 1'b0;
      while (destination_writes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Drive one register write; leave the enable high for a following write.
   task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [SIZE_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      case (idx)
         REG_SOURCE_FORMAT: regs.source_format = value[FMT_W-1:0];
         REG_TARGET_FORMAT: regs.target_format = value[FMT_W-1:0];
         REG_SOURCE_WIDTH:  regs.source_width  = value;
         REG_SOURCE_HEIGHT: regs.source_height = value;
         REG_TARGET_WIDTH:  regs.target_width  = value;
         REG_TARGET_HEIGHT: regs.target_height = value;
         REG_DEPTH_SHIFT:   regs.depth_shift   = value[SHIFT_W-1:0];
         default: ;
      endcase
      // any listed register restarts the image
      if (idx <= REG_DEPTH_SHIFT) begin
         scan_col = '0;
         scan_row = '0;
      end
   endtask

   task automatic program_regs(input logic [SIZE_W-1:0] sf, tf, sw, sh, tw, th, shift);
      drain_and_idle();
      write_reg(REG_SOURCE_FORMAT, sf);
      write_reg(REG_TARGET_FORMAT, tf);
      write_reg(REG_SOURCE_WIDTH, sw);
      write_reg(REG_SOURCE_HEIGHT, sh);
      write_reg(REG_TARGET_WIDTH, tw);
      write_reg(REG_TARGET_HEIGHT, th);
      write_reg(REG_DEPTH_SHIFT, shift);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   task automatic try_size(input int sw, sh, tw, th);
      program_regs(FMT_RGB888, FMT_RGBA8888, sw, sh, tw, th, 8);
      send_pixel(random_pixel());
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset leaves all sizes at zero, so the first item is a size reject.
   // Then program everything but the shift and check the default of 8.
   task automatic test_reset_defaults();
      send_pixel('1);
      drain_and_idle();
      write_reg(REG_SOURCE_FORMAT, FMT_D16);
      write_reg(REG_TARGET_FORMAT, FMT_RGB888);
      write_reg(REG_SOURCE_WIDTH, 2);
      write_reg(REG_SOURCE_HEIGHT, 1);
      write_reg(REG_TARGET_WIDTH, 2);
      write_reg(REG_TARGET_HEIGHT, 1);
      csr_write_enable <= 1'b0;
      send_pixel(32'h1234_ABCD);
   endtask

   // Every supported pair, a few unsupported ones, and a code past the list.
   task automatic test_format_pairs();
      logic [PIX_W-1:0] scratch;
      int               pick;
      pick = 0;
      for (int sf = 0; sf <= 4; sf++) begin
         for (int tf = 0; tf <= 4; tf++) begin
            if (convert_pixel(3'(sf), 3'(tf), 0, 0, scratch) ||
                (3'(sf) == FMT_RGB565 && 3'(tf) == FMT_RGBA8888) ||
                (3'(sf) == FMT_I8 && 3'(tf) == FMT_RGB888) ||
                (3'(sf) == FMT_RGBA8888 && 3'(tf) == FMT_D16)) begin
               // alternate the depth shift between its extremes
               program_regs(sf, tf, 3, 2, 5, 4, (pick % 2) ? 15 : 0);
               case (pick % 3)
                  0:       send_pixel('1);
                  1:       send_pixel('0);
                  default: send_pixel($urandom);
               endcase
               pick++;
            end
         end
      end
      program_regs(FMT_UNDEFINED, FMT_RGB565, 3, 2, 5, 4, 8);
      send_pixel($urandom);
   endtask

   // Pair check wins over size check; each size rule; the largest legal sizes.
   task automatic test_size_checks();
      program_regs(FMT_RESERVED, FMT_RGBA8888, 0, 0, 0, 0, 8);
      send_pixel($urandom);
      try_size(0, 4, 4, 4);
      try_size(4, 0, 4, 4);
      try_size(4, 4, 0, 4);
      try_size(4, 4, 4, 0);
      try_size(5, 2, 4, 4);
      try_size(2, 5, 4, 4);
      try_size(MAX_WIDTH + 1, 1, 8191, 8191);
      try_size(1, MAX_HEIGHT + 1, 8191, 8191);
      try_size(MAX_WIDTH, MAX_HEIGHT, MAX_WIDTH, MAX_HEIGHT);
      try_size(1, 1, 8191, 8191);
   endtask

   // A write past the list keeps the scan; a rewrite of a real register
   // restarts it even when the value does not change.
   task automatic test_register_writes();
      program_regs(FMT_RGB888, FMT_RGBA8888, 3, 2, 4, 4, 5);
      repeat (2) send_pixel(random_pixel());
      drain_and_idle();
      write_reg(REG_UNUSED, $urandom_range(0, 8191));
      csr_write_enable <= 1'b0;
      repeat (4) send_pixel(random_pixel());
      repeat (2) send_pixel(random_pixel());
      drain_and_idle();
      write_reg(REG_DEPTH_SHIFT, 5);
      csr_write_enable <= 1'b0;
      // a full image plus one item that wraps into the next
      repeat (7) send_pixel(random_pixel());
   endtask

   // The start of one tall column on the widest stride and of one full-width row.
   task automatic test_extreme_sizes();
      stalls_enabled = 1'b0;
      program_regs(FMT_RGBA8888, FMT_RGBA8888, 1, MAX_HEIGHT, 8191, MAX_HEIGHT, 0);
      repeat (EXTREME_ITEMS) send_pixel($urandom);
      program_regs(FMT_RGB888, FMT_RGB565, MAX_WIDTH, 1, MAX_WIDTH, MAX_HEIGHT, 0);
      repeat (EXTREME_ITEMS) send_pixel($urandom);
      stalls_enabled = 1'b1;
   endtask

   // Random settings: mostly legal images of random content, some noise.
   task automatic test_random_images();
      logic [PIX_W-1:0]  scratch;
      logic [FMT_W-1:0]  sf, tf;
      int                sw, sh, tw, th, count, start;
      logic [SIZE_W-1:0] sf_data, tf_data;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         stalls_enabled = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0: begin
               // unsupported pair, random sizes
               do begin
                  sf = $urandom_range(0, 7);
                  tf = $urandom_range(0, 7);
               end while (convert_pixel(sf, tf, 0, 0, scratch));
               sw = $urandom_range(0, 8);
               sh = $urandom_range(0, 8);
               tw = $urandom_range(0, 8);
               th = $urandom_range(0, 8);
               count = $urandom_range(1, 4);
            end
            1: begin
               // legal pair, broken sizes
               do begin
                  sf = $urandom_range(0, 4);
                  tf = $urandom_range(0, 4);
               end while (!convert_pixel(sf, tf, 0, 0, scratch));
               sw = $urandom_range(1, 8);
               sh = $urandom_range(1, 8);
               tw = sw + 1;
               th = sh + 1;
               case ($urandom_range(0, 4))
                  0: tw = $urandom_range(0, sw - 1);
                  1: th = $urandom_range(0, sh - 1);
                  2: begin sw = $urandom_range(MAX_WIDTH + 1, 8191); tw = 8191; end
                  3: begin sh = $urandom_range(MAX_HEIGHT + 1, 8191); th = 8191; end
                  default: sw = 0;
               endcase
               count = $urandom_range(1, 4);
            end
            default: begin
               do begin
                  sf = $urandom_range(0, 4);
                  tf = $urandom_range(0, 4);
               end while (!convert_pixel(sf, tf, 0, 0, scratch));
               case ($urandom_range(0, 7))
                  0: begin
                     // wide rows, only a few items of them
                     sw = $urandom_range(0, 1) ? MAX_WIDTH : $urandom_range(1, MAX_WIDTH);
                     sh = $urandom_range(1, 4);
                     tw = $urandom_range(sw, 8191);
                     th = $urandom_range(sh, 8191);
                     count = $urandom_range(1, 40);
                  end
                  1: begin
                     // narrow image on a wide stride for large addresses
                     sw = $urandom_range(1, 4);
                     sh = $urandom_range(4, 64);
                     tw = $urandom_range(MAX_WIDTH, 8191);
                     th = $urandom_range(sh, 8191);
                     count = sw * sh;
                  end
                  default: begin
                     sw = $urandom_range(1, 8);
                     sh = $urandom_range(1, 6);
                     tw = sw + $urandom_range(0, 8);
                     th = sh + $urandom_range(0, 4);
                     count = sw * sh * $urandom_range(1, 3);
                     // sometimes stop short of the end of the image
                     if ($urandom_range(0, 3) == 0)
                        count = count - $urandom_range(0, sw * sh - 1);
                  end
               endcase
            end
         endcase
         // put junk in the unused upper bits of the format writes now and then
         sf_data = sf;
         tf_data = tf;
         if ($urandom_range(0, 3) == 0) begin
            sf_data = {10'($urandom), sf};
            tf_data = {10'($urandom), tf};
         end
         program_regs(sf_data, tf_data, sw, sh, tw, th, $urandom_range(0, 15));
         repeat (count) send_pixel(random_pixel());
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side: random back-pressure, then compare with the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_hold <= 0;
      end else if (rsp_ready) begin
         if (rsp_valid) begin
            // item taken: draw the stall before the next one
            ready_draw = stalls_enabled ? $urandom_range(0, 15) : 0;
            if (ready_draw > 0) begin
               rsp_ready  <= 1'b0;
               ready_hold <= ready_draw - 1;
            end
         end
      end else if (ready_hold == 0) begin
         rsp_ready <= 1'b1;
      end else begin
         ready_hold <= ready_hold - 1;
      end
   end

   task automatic compare_field(input string field, input logic [PIX_W-1:0] want,
                                input logic [PIX_W-1:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected 'h%0h, actual 'h%0h",
                  $time, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : result_check
      pixel_write_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (destination_writes.size() == 0) begin
            $display("%0t ns: result with nothing outstanding, pixel_out 'h%0h status %0d",
                     $time, rsp_pixel_out, rsp_status);
            mismatches++;
         end else begin
            want = destination_writes.pop_front();
            compare_field("pixel_out", want.pixel, rsp_pixel_out);
            compare_field("byte_count", 32'(want.count), 32'(rsp_byte_count));
            compare_field("byte_address", 32'(want.address), 32'(rsp_byte_address));
            compare_field("status", 32'(want.status), 32'(rsp_status));
            compare_field("image_done", 32'(want.done), 32'(rsp_image_done));
            if (want.done) images_seen++;
            if (want.status != STATUS_OK) rejects_seen++;
         end
      end
   end

   // Stop a hung run: count cycles in which neither channel moves an item
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
                  $time, WATCHDOG_LIMIT, destination_writes.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      // mirror the reset values of the block
      regs             = '0;
      regs.depth_shift = 4'd8;
      scan_col         = '0;
      scan_row         = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_format_pairs();
      test_size_checks();
      test_register_writes();
      test_extreme_sizes();
      test_random_images();

      drain_and_idle();
      repeat (8) @(posedge clock);
      $display("Run covered %0d items over %0d register settings,", items_sent, settings_used);
      $display("with %0d complete images and %0d rejected items.", images_seen, rejects_seen);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/pfc_pkg.sv
rtl/pfc_csr.sv
rtl/pfc_scan.sv
rtl/pfc_convert.sv
rtl/pixel_format_converter.sv
rtl/pfc_checker.sv
tb/sv/pixel_format_converter_test.sv
